>>> src/rsa_key_exponent_derivation_defines.svh
// Assertion macros shared by the key exponent derivation RTL.
`ifndef RSA_KEY_EXPONENT_DERIVATION_DEFINES_SVH
`define RSA_KEY_EXPONENT_DERIVATION_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RKD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RKD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rkd_pkg.sv
// Package with widths and status codes of the key exponent derivation block.
`default_nettype none
package rkd_pkg;
	localparam int FACTOR_BITS_DEF = 31;
	localparam int FIELD_W = 31;
	localparam int IN_DATA_W = 64;
	localparam int PHI_W = 62;
	localparam int PRIV_W = 63;
	localparam int T_W = 64;
	localparam int OUT_DATA_W = 128;
	localparam int STAT_W = 2;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK = 2'd0,
		STAT_FACTOR_LOW = 2'd1,
		STAT_PHI_LOW = 2'd2
	} stat_t;
endpackage
`default_nettype wire

>>> src/rsa_key_exponent_derivation.sv
// Top level: derives public and private RSA exponents from two factors.
//
// channel | direction | handshake          | contents
// s_*     | in        | s_tvalid/s_tready  | tdata: p_value, q_value
// m_*     | out       | m_tvalid/m_tready  | tdata: public/private exponent; tuser: status
//
// One factor pair is in work at a time; s_tready is high only while no pair is in work.
// phi is formed in a bit-serial shift-add multiplier. Each Euclid step runs the
// bit-serial restoring divider (ST_DIV), then an update state (ST_UPD).
// Every candidate e runs a full extended Euclid; error pairs skip it: a low
// factor goes straight to the write state, a low phi right after the multiplier.
// Reset clears the control state; the result register holds the last result while
// m_tready is low, and a new pair is taken while that result waits.
`default_nettype none
`include "rsa_key_exponent_derivation_defines.svh"
module rsa_key_exponent_derivation #(
	parameter int FACTOR_BITS = rkd_pkg::FACTOR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// p_value [30:0], q_value [61:31], zero [63:62]
	input  wire logic [rkd_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// public_exponent [61:0], private_exponent [124:62], zero [127:125]
	output logic [rkd_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status [1:0]
	output logic [rkd_pkg::STAT_W-1:0]         m_tuser
);
	import rkd_pkg::*;

	localparam int CNT_W = $clog2(PHI_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_UPD,
		ST_FIN1,
		ST_FIN2,
		ST_WRITE
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FACTOR_BITS-1:0] pm_q, qm_q;
	logic [PHI_W-1:0] phi_q, e_q, r0_q, r1_q, n_q, rem_q;
	logic signed [T_W-1:0] t0_q, t1_q, acc_q;
	logic [PRIV_W-1:0] dv_q;
	stat_t res_stat_q, stat_q;
	logic [PHI_W-1:0] pub_q;
	logic [PRIV_W-1:0] priv_q;
	logic out_valid_q;

	logic [FACTOR_BITS-1:0] p_in, q_in;
	logic [PHI_W:0] rtry, rdiff;
	logic rge;
	logic signed [T_W-1:0] phi_s, fix_sum;

	assign p_in = s_tdata[FACTOR_BITS-1:0];
	assign q_in = s_tdata[FIELD_W +: FACTOR_BITS];

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign rtry = {rem_q, n_q[PHI_W-1]};
	assign rdiff = rtry - {1'b0, r1_q};
	assign rge = rtry >= {1'b0, r1_q};
	assign phi_s = $signed({{(T_W-PHI_W){1'b0}}, phi_q});
	assign fix_sum = t0_q + phi_s;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_DATA_W-PHI_W-PRIV_W){1'b0}}, priv_q, pub_q};
	assign m_tuser = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			// The write state handles the result register itself.
			if (m_tready && state_q != ST_WRITE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						e_q <= '0;
						dv_q <= '0;
						pm_q <= p_in - FACTOR_BITS'(1);
						qm_q <= q_in - FACTOR_BITS'(1);
						phi_q <= '0;
						cnt_q <= '0;
						if (p_in < FACTOR_BITS'(2) || q_in < FACTOR_BITS'(2)) begin
							res_stat_q <= STAT_FACTOR_LOW;
							state_q <= ST_WRITE;
						end else begin
							res_stat_q <= STAT_OK;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					// Multiplier bits are taken most significant first.
					phi_q <= {phi_q[PHI_W-2:0], 1'b0}
						+ (qm_q[FACTOR_BITS-1] ? PHI_W'(pm_q) : '0);
					qm_q <= qm_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FACTOR_BITS-1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (phi_q < PHI_W'(3)) begin
						res_stat_q <= STAT_PHI_LOW;
						state_q <= ST_WRITE;
					end else begin
						e_q <= PHI_W'(2);
						r0_q <= phi_q;
						r1_q <= PHI_W'(2);
						n_q <= phi_q;
						t0_q <= '0;
						t1_q <= T_W'(1);
						rem_q <= '0;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// acc collects quotient times t1 as the quotient bits come out.
					rem_q <= rge ? rdiff[PHI_W-1:0] : rtry[PHI_W-1:0];
					n_q <= n_q << 1;
					acc_q <= (acc_q <<< 1) + (rge ? t1_q : '0);
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PHI_W-1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					cnt_q <= '0;
					acc_q <= '0;
					if (rem_q != '0) begin
						r0_q <= r1_q;
						r1_q <= rem_q;
						n_q <= r1_q;
						rem_q <= '0;
						t0_q <= t1_q;
						t1_q <= t0_q - acc_q;
						state_q <= ST_DIV;
					end else if (r1_q == PHI_W'(1)) begin
						// gcd is one: t1 is the inverse of e.
						t0_q <= t1_q;
						state_q <= ST_FIN1;
					end else begin
						// Not coprime: restart Euclid with the next candidate.
						e_q <= e_q + PHI_W'(1);
						r0_q <= phi_q;
						r1_q <= e_q + PHI_W'(1);
						n_q <= phi_q;
						rem_q <= '0;
						t0_q <= '0;
						t1_q <= T_W'(1);
						state_q <= ST_DIV;
					end
				end
				ST_FIN1: begin
					dv_q <= t0_q[T_W-1] ? fix_sum[PRIV_W-1:0] : t0_q[PRIV_W-1:0];
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					// The inverse must differ from e itself.
					if (dv_q == {1'b0, e_q}) begin
						dv_q <= dv_q + {1'b0, phi_q};
					end
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (!out_valid_q || m_tready) begin
						pub_q <= e_q;
						priv_q <= dv_q;
						stat_q <= res_stat_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RKD_ASSERT_NOW(a_div_count, state_q == ST_DIV, cnt_q <= CNT_W'(PHI_W-1), "divider count overrun")
	`RKD_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == '0, "error result with exponent")
	`RKD_ASSERT_NOW(a_ok_e, m_tvalid && m_tuser == STAT_OK, m_tdata[PHI_W-1:0] >= PHI_W'(2), "public exponent below two")
	`RKD_ASSERT_NEXT(a_accept, s_tvalid && s_tready, !s_tready, "second pair taken while busy")
endmodule
`default_nettype wire

>>> tb/sv/rsa_key_exponent_derivation_checker.sv
// Checker that predicts the exponents for each accepted factor pair and compares results.
module rsa_key_exponent_derivation_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [rkd_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [rkd_pkg::OUT_DATA_W-1:0] m_tdata,
	input  wire logic [rkd_pkg::STAT_W-1:0]    m_tuser,
	output int                                 failures,
	output int                                 pending
);
	import rkd_pkg::*;

	typedef struct {
		logic [PHI_W-1:0]  pub_exp;
		logic [PRIV_W-1:0] priv_exp;
		stat_t             stat;
	} key_t;

	key_t key_q[$];

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Extended Euclid; the Bezout coefficient is kept as a signed 64-bit value.
	function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] m);
		longint t0, t1, tn;
		logic [63:0] r0, r1, rn, qt;
		t0 = 0;
		t1 = 1;
		r0 = m;
		r1 = a % m;
		while (r1 != 0) begin
			qt = r0 / r1;
			rn = r0 - qt * r1;
			tn = t0 - longint'(qt) * t1;
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		if (t0 < 0)
			return t0 + longint'(m);
		return t0;
	endfunction

	function automatic key_t derive_key(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
		key_t k;
		logic [63:0] phi, e, d;
		k.pub_exp = '0;
		k.priv_exp = '0;
		k.stat = STAT_OK;
		if (p < 2 || q < 2) begin
			k.stat = STAT_FACTOR_LOW;
			return k;
		end
		phi = ((64'(p) - 1) * (64'(q) - 1)) & ((64'd1 << PHI_W) - 1);
		if (phi < 3) begin
			k.stat = STAT_PHI_LOW;
			return k;
		end
		e = 2;
		while (e < phi && gcd64(phi, e) != 1)
			e++;
		d = inverse_mod(e, phi);
		// When the inverse equals e itself, the next solution up is taken.
		if (d == e)
			d = d + phi;
		k.pub_exp = e[PHI_W-1:0];
		k.priv_exp = d[PRIV_W-1:0];
		return k;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_t want;
		if (!arst_n) begin
			key_q.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				key_q.push_back(derive_key(s_tdata[FIELD_W-1:0], s_tdata[2*FIELD_W-1:FIELD_W]));
			if (m_tvalid && m_tready) begin
				if (key_q.size() == 0) begin
					$display("%0t: result with nothing expected: pub %0d priv %0d status %0d",
						$time, m_tdata[61:0], m_tdata[124:62], m_tuser);
					failures <= failures + 1;
				end else begin
					want = key_q.pop_front();
					if (m_tdata[61:0] !== want.pub_exp || m_tdata[124:62] !== want.priv_exp
							|| m_tuser !== want.stat) begin
						$display("%0t: expected pub %0d priv %0d status %0d, got pub %0d priv %0d status %0d",
							$time, want.pub_exp, want.priv_exp, want.stat,
							m_tdata[61:0], m_tdata[124:62], m_tuser);
						failures <= failures + 1;
					end
				end
			end
			pending <= key_q.size();
		end
	end
endmodule

>>> tb/sv/rsa_key_exponent_derivation_tb.sv
// Testbench top: drives factor pairs into the block and gives the verdict.
module rsa_key_exponent_derivation_tb;
	import rkd_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;
	localparam int LONG_HOLD = 4000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;
	int failures;
	int pending;

	// Idle chances in percent for the sender and the receiver; changed per phase.
	int send_idle_pct;
	int recv_idle_pct;
	// Set once by the stimulus to make the receiver hold off for a long stretch.
	logic hold_request;
	int cycles;

	rsa_key_exponent_derivation dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	rsa_key_exponent_derivation_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure at the falling edge, plus one long hold-off
	// that is counted here so the sender keeps offering pairs meanwhile.
	initial begin
		int held;
		bit hold_done;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				m_tready = 1'b0;
				for (held = 0; held < LONG_HOLD; held++)
					@(negedge clk);
				hold_done = 1'b1;
			end
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offers one factor pair and returns after the transfer, at the next falling edge.
	task automatic send_pair(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {2'b00, q, p};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Mostly small factors keep the serial Euclid loops short; a few reach full width.
	function automatic logic [FIELD_W-1:0] pick_factor();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return FIELD_W'($urandom_range(3));
		if (sel < 11)
			return FIELD_W'($urandom);
		return FIELD_W'($urandom_range(255, 2));
	endfunction

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int i;
		int phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pairs: factor below two, phi below three, inverse equal to e,
		// and the field extremes.
		send_pair(31'd0, 31'd0);
		send_pair(31'd1, 31'd7);
		send_pair(31'd7, 31'd1);
		send_pair(31'd0, 31'h7fffffff);
		send_pair(31'd2, 31'd2);
		send_pair(31'd2, 31'd3);
		send_pair(31'd3, 31'd2);
		send_pair(31'd2, 31'd5);
		send_pair(31'd3, 31'd3);
		send_pair(31'd3, 31'd5);
		send_pair(31'd5, 31'd7);
		send_pair(31'd11, 31'd13);
		send_pair(31'd61, 31'd53);
		send_pair(31'd2, 31'd4);
		send_pair(31'd65537, 31'd257);
		send_pair(31'h7fffffff, 31'h7fffffff);
		send_pair(31'h7fffffff, 31'd3);
		send_pair(31'h55555555, 31'h2aaaaaaa);
		drain();

		// Three phases of random pairs: receiver idles more, then sender, then neither.
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 62 : 0;
			recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 28 : 0;
			for (i = 0; i < 33; i++) begin
				if (phase == 2 && i == 5)
					hold_request = 1'b1;
				send_pair(pick_factor(), pick_factor());
			end
			// Sender pauses until every expected result has come back.
			drain();
		end

		repeat (200) @(negedge clk);
		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
